// ===== hw/rtl/skf_pkg.sv =====
// package for the three-axis scalar kalman filter: types, widths and codes
`timescale 1ns / 1ps

package skf_pkg;

    localparam int NFIELDS           = 3;
    localparam int RAW_W             = 16;
    localparam int EST_W             = 32;
    localparam int COV_W             = 32;
    localparam int REG_W             = 31;
    localparam int GAIN_FRAC         = 30;
    localparam int GAIN_W            = GAIN_FRAC + 1;
    localparam int CNT_W             = $clog2(GAIN_W);
    localparam int CFG_IDX_W         = 2;
    localparam int DEF_AXES          = 3;
    localparam int DEF_COV_FRAC_BITS = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;

    typedef struct packed {
        logic signed [RAW_W-1:0] x_raw;
        logic signed [RAW_W-1:0] y_raw;
        logic signed [RAW_W-1:0] z_raw;
    } t_in_item;

    typedef struct packed {
        logic signed [EST_W-1:0] x_filtered;
        logic signed [EST_W-1:0] y_filtered;
        logic signed [EST_W-1:0] z_filtered;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic div_step;
        logic prep;
        logic mul_step;
        logic finish;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_MUL,
        ST_FIN
    } t_state;

endpackage

// ===== hw/rtl/skf_lane.sv =====
// one filter axis: bit-serial gain divider, two shift-add multipliers, axis state
`timescale 1ns / 1ps

module skf_lane #(
    parameter int COV_FRAC_BITS = skf_pkg::DEF_COV_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  skf_pkg::t_lane_ctl                i_ctl,
    input  logic signed [skf_pkg::RAW_W-1:0]  i_raw,
    input  logic        [skf_pkg::REG_W-1:0]  i_q,
    input  logic        [skf_pkg::REG_W-1:0]  i_r,
    output logic        [skf_pkg::EST_W-1:0]  o_est_next
);

    localparam int EST_W  = skf_pkg::EST_W;
    localparam int COV_W  = skf_pkg::COV_W;
    localparam int RAW_W  = skf_pkg::RAW_W;
    localparam int REG_W  = skf_pkg::REG_W;
    localparam int GAIN_W = skf_pkg::GAIN_W;
    localparam int DEN_W  = COV_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int MAG_W  = EST_W + 1;

    localparam logic [COV_W-1:0]  COV_ONE  = {{(COV_W-1){1'b0}}, 1'b1} << COV_FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {(GAIN_W-1){1'b0}}};

    logic [EST_W-1:0]  r_est,     n_est;
    logic [COV_W-1:0]  r_cov,     n_cov;
    logic              r_primed,  n_primed;
    logic [EST_W-1:0]  r_m,       n_m;
    logic [COV_W-1:0]  r_p,       n_p;
    logic [DEN_W-1:0]  r_den,     n_den;
    logic              r_den_zero, n_den_zero;
    logic [REM_W-1:0]  r_rem,     n_rem;
    logic [GAIN_W-1:0] r_k,       n_k;
    logic [MAG_W-1:0]  r_a1,      n_a1;
    logic              r_neg,     n_neg;
    logic [GAIN_W-1:0] r_m1,      n_m1;
    logic [GAIN_W-1:0] r_m2,      n_m2;
    logic [MAG_W-1:0]  r_hi1,     n_hi1;
    logic [GAIN_W-1:0] r_lo1,     n_lo1;
    logic [MAG_W-1:0]  r_hi2,     n_hi2;
    logic [GAIN_W-1:0] r_lo2,     n_lo2;

    logic [COV_W:0]    w_p_sum;
    logic [COV_W-1:0]  w_p_sat;
    logic              w_ge;
    logic [REM_W-1:0]  w_rem_sel;
    logic [GAIN_W-1:0] w_k_eff;
    logic [EST_W:0]    w_diff;
    logic [MAG_W:0]    w_sum1;
    logic [MAG_W:0]    w_sum2;
    logic [MAG_W:0]    w_rnd1;
    logic [MAG_W:0]    w_rnd2;
    logic [EST_W+1:0]  w_est_ext;
    logic [EST_W+1:0]  w_est_new;
    logic [EST_W-1:0]  w_est_upd;
    logic [COV_W-1:0]  w_cov_upd;

    always_comb begin
        // predicted covariance, saturating
        w_p_sum = {1'b0, r_cov} + {{(COV_W+1-REG_W){1'b0}}, i_q};
        w_p_sat = w_p_sum[COV_W] ? {COV_W{1'b1}} : w_p_sum[COV_W-1:0];

        // restoring division step
        w_ge      = (r_rem >= {1'b0, r_den});
        w_rem_sel = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

        w_k_eff = r_den_zero ? '0 : r_k;
        w_diff  = {r_m[EST_W-1], r_m} - {r_est[EST_W-1], r_est};

        // shift-add partial sums
        w_sum1 = {1'b0, r_hi1} + (r_m1[0] ? {1'b0, r_a1} : '0);
        w_sum2 = {1'b0, r_hi2} + (r_m2[0] ? {2'b0, r_p} : '0);

        // products shifted down by the gain fraction, rounded
        w_rnd1 = {r_hi1, r_lo1[GAIN_W-1]} + {{MAG_W{1'b0}}, r_lo1[GAIN_W-2]};
        w_rnd2 = {r_hi2, r_lo2[GAIN_W-1]} + {{MAG_W{1'b0}}, r_lo2[GAIN_W-2]};

        w_est_ext = {{2{r_est[EST_W-1]}}, r_est};
        w_est_new = r_neg ? (w_est_ext - w_rnd1) : (w_est_ext + w_rnd1);
        w_est_upd = r_primed ? w_est_new[EST_W-1:0] : r_m;
        w_cov_upd = r_primed ? w_rnd2[COV_W-1:0] : r_cov;
    end

    assign o_est_next = w_est_upd;

    always_comb begin
        n_est      = r_est;
        n_cov      = r_cov;
        n_primed   = r_primed;
        n_m        = r_m;
        n_p        = r_p;
        n_den      = r_den;
        n_den_zero = r_den_zero;
        n_rem      = r_rem;
        n_k        = r_k;
        n_a1       = r_a1;
        n_neg      = r_neg;
        n_m1       = r_m1;
        n_m2       = r_m2;
        n_hi1      = r_hi1;
        n_lo1      = r_lo1;
        n_hi2      = r_hi2;
        n_lo2      = r_lo2;

        if (i_ctl.start) begin
            n_m        = {i_raw, {(EST_W-RAW_W){1'b0}}};
            n_p        = w_p_sat;
            n_den      = {1'b0, w_p_sat} + {{(DEN_W-REG_W){1'b0}}, i_r};
            n_den_zero = (w_p_sat == '0) && (i_r == '0);
            n_rem      = {2'b0, w_p_sat};
            n_k        = '0;
        end

        if (i_ctl.div_step) begin
            n_rem = {w_rem_sel[REM_W-2:0], 1'b0};
            n_k   = {r_k[GAIN_W-2:0], w_ge};
        end

        if (i_ctl.prep) begin
            n_neg = w_diff[EST_W];
            n_a1  = w_diff[EST_W] ? (~w_diff + 1'b1) : w_diff;
            n_m1  = w_k_eff;
            n_m2  = GAIN_ONE - w_k_eff;
            n_hi1 = '0;
            n_lo1 = '0;
            n_hi2 = '0;
            n_lo2 = '0;
        end

        if (i_ctl.mul_step) begin
            n_hi1 = w_sum1[MAG_W:1];
            n_lo1 = {w_sum1[0], r_lo1[GAIN_W-1:1]};
            n_hi2 = w_sum2[MAG_W:1];
            n_lo2 = {w_sum2[0], r_lo2[GAIN_W-1:1]};
            n_m1  = {1'b0, r_m1[GAIN_W-1:1]};
            n_m2  = {1'b0, r_m2[GAIN_W-1:1]};
        end

        if (i_ctl.finish) begin
            n_est    = w_est_upd;
            n_cov    = w_cov_upd;
            n_primed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est    <= '0;
            r_cov    <= COV_ONE;
            r_primed <= 1'b0;
        end else begin
            r_est    <= n_est;
            r_cov    <= n_cov;
            r_primed <= n_primed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m        <= n_m;
        r_p        <= n_p;
        r_den      <= n_den;
        r_den_zero <= n_den_zero;
        r_rem      <= n_rem;
        r_k        <= n_k;
        r_a1       <= n_a1;
        r_neg      <= n_neg;
        r_m1       <= n_m1;
        r_m2       <= n_m2;
        r_hi1      <= n_hi1;
        r_lo1      <= n_lo1;
        r_hi2      <= n_hi2;
        r_lo2      <= n_lo2;
    end

endmodule

// ===== hw/rtl/scalar_kalman_filter_3axis_top.sv =====
// new samples are taken only in idle, after the previous result is registered; each runs
// the 31-step bit-serial gain divider, a prep step and the 31-step shift-add multipliers
// in each axis lane, then waits in finish while the output stalls; axes run in parallel
// reset: synchronous active-low; estimates clear to zero, covariances to one,
// the first sample after reset loads the estimates directly, noise registers take defaults
`timescale 1ns / 1ps

module scalar_kalman_filter_3axis_top #(
    parameter int AXES          = skf_pkg::DEF_AXES,
    parameter int COV_FRAC_BITS = skf_pkg::DEF_COV_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  skf_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output skf_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_wr_en,
    input  logic [skf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [skf_pkg::REG_W-1:0]          i_cfg_wdata
);

    localparam int NFIELDS = skf_pkg::NFIELDS;
    localparam int LANES   = (AXES < NFIELDS) ? AXES : NFIELDS;
    localparam int REG_W   = skf_pkg::REG_W;
    localparam int EST_W   = skf_pkg::EST_W;
    localparam int RAW_W   = skf_pkg::RAW_W;
    localparam int CNT_W   = skf_pkg::CNT_W;

    localparam logic [63:0] COV_ONE64 = 64'd1 << COV_FRAC_BITS;
    localparam logic [63:0] Q_RST64   = (64'd15 * COV_ONE64 + 64'd5000) / 64'd10000;
    localparam logic [63:0] R_RST64   = (64'd5 * COV_ONE64 + 64'd50) / 64'd100;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(skf_pkg::GAIN_W - 1);

    skf_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [REG_W-1:0]   r_q;
    logic [REG_W-1:0]   r_r;
    logic               r_out_valid, n_out_valid;
    skf_pkg::t_out_item r_out,       n_out;
    skf_pkg::t_lane_ctl w_ctl;
    logic               w_slot_free;
    logic               w_in_ready;

    logic signed [RAW_W-1:0] w_raw [NFIELDS];
    logic [EST_W-1:0]        w_est [NFIELDS];

    always_comb begin
        w_raw[0] = i_in_data.x_raw;
        w_raw[1] = i_in_data.y_raw;
        w_raw[2] = i_in_data.z_raw;
    end

    for (genvar g = 0; g < NFIELDS; g++) begin : g_axis
        if (g < LANES) begin : g_lane
            skf_lane #(
                .COV_FRAC_BITS(COV_FRAC_BITS)
            ) u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_raw      (w_raw[g]),
                .i_q        (r_q),
                .i_r        (r_r),
                .o_est_next (w_est[g])
            );
        end else begin : g_absent
            assign w_est[g] = '0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= Q_RST64[REG_W-1:0];
            r_r <= R_RST64[REG_W-1:0];
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                skf_pkg::REG_PROCESS_NOISE: r_q <= i_cfg_wdata;
                skf_pkg::REG_MEASURE_NOISE: r_r <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        w_ctl      = '0;
        w_in_ready = 1'b0;

        case (r_state)
            skf_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_ctl.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = skf_pkg::ST_DIV;
                end
            end
            skf_pkg::ST_DIV: begin
                w_ctl.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = skf_pkg::ST_PREP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            skf_pkg::ST_PREP: begin
                w_ctl.prep = 1'b1;
                n_state    = skf_pkg::ST_MUL;
            end
            skf_pkg::ST_MUL: begin
                w_ctl.mul_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = skf_pkg::ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            skf_pkg::ST_FIN: begin
                // wait for the output register to free up
                if (w_slot_free) begin
                    w_ctl.finish = 1'b1;
                    n_state      = skf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (w_ctl.finish) begin
            n_out.x_filtered = w_est[0];
            n_out.y_filtered = w_est[1];
            n_out.z_filtered = w_est[2];
            n_out_valid      = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skf_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
